@@ design/nnis_pkg.sv @@
// Shared types and constants for the nearest-neighbor image scaler.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package nnis_pkg;

    // Field and datapath widths fixed by the interface.
    localparam int SIZE_W     = 9;   // frame size register
    localparam int IDX_W      = 8;   // row or column index of a word
    localparam int PROD_W     = 17;  // index times size
    localparam int QUO_W      = 9;   // mapped source index
    localparam int CNT_W      = 4;   // divider step counter
    localparam int WORD_W     = 32;  // pixel field of a word
    localparam int REG_W      = 32;  // configuration data bus
    localparam int CFG_ADDR_W = 4;   // configuration byte address

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SRC_ROWS = 2'd0;
    localparam logic [1:0] REG_SRC_COLS = 2'd1;
    localparam logic [1:0] REG_DST_ROWS = 2'd2;
    localparam logic [1:0] REG_DST_COLS = 2'd3;

    // Input word kinds as carried on tuser.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    // What the back end has to do with a queued command.
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_FETCH,
        OP_ERROR
    } op_t;

    // Frame sizes after saturation to the store dimensions.
    typedef struct packed {
        logic [SIZE_W-1:0] src_rows;
        logic [SIZE_W-1:0] src_cols;
        logic [SIZE_W-1:0] dst_rows;
        logic [SIZE_W-1:0] dst_cols;
    } cfg_t;

    // One classified command in the queue.
    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  row_idx;
        logic [IDX_W-1:0]  col_idx;
        logic [PROD_W-1:0] row_prod;
        logic [PROD_W-1:0] col_prod;
        logic [WORD_W-1:0] pixel;
    } cmd_t;

    // Queue occupancy flags.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

`default_nettype wire

@@ design/nnis_front.sv @@
// Front end of the scaler: accepts input words, checks them against the
// frame sizes and forms the mapping products. Depends on nnis_pkg.
`default_nettype none

module nnis_front (
    input  wire nnis_pkg::cfg_t         cfg,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [47:0]            s_tdata,   // row_index, col_index, pixel_in
    input  wire logic                   s_tuser,   // kind
    input  wire nnis_pkg::fifo_status_t fifo_status,
    output logic                        push,
    output nnis_pkg::cmd_t              cmd
);
    import nnis_pkg::*;

    logic [IDX_W-1:0]  row_idx;
    logic [IDX_W-1:0]  col_idx;
    logic [WORD_W-1:0] pixel;
    logic              load_err;
    logic              fetch_err;

    // Unpack the word.
    assign row_idx = s_tdata[7:0];
    assign col_idx = s_tdata[15:8];
    assign pixel   = s_tdata[47:16];

    // Take a word whenever the queue has room.
    assign s_tready = !fifo_status.full;
    assign push     = s_tvalid && !fifo_status.full;

    // Range checks for both kinds of word.
    assign load_err  = ({1'b0, row_idx} >= cfg.src_rows) || ({1'b0, col_idx} >= cfg.src_cols);
    assign fetch_err = ({1'b0, row_idx} >= cfg.dst_rows) || ({1'b0, col_idx} >= cfg.dst_cols)
                       || (cfg.src_rows == '0) || (cfg.src_cols == '0);

    // Classify and form index times source size for each axis.
    always_comb
    begin
        cmd.row_idx  = row_idx;
        cmd.col_idx  = col_idx;
        cmd.pixel    = pixel;
        cmd.row_prod = PROD_W'(row_idx) * PROD_W'(cfg.src_rows);
        cmd.col_prod = PROD_W'(col_idx) * PROD_W'(cfg.src_cols);
        case (s_tuser)
            KIND_LOAD:  cmd.op = load_err ? OP_ERROR : OP_LOAD;
            KIND_FETCH: cmd.op = fetch_err ? OP_ERROR : OP_FETCH;
            default:    cmd.op = OP_ERROR;
        endcase
    end

endmodule

`default_nettype wire

@@ design/nnis_fifo.sv @@
// Two-entry command queue between the front and back ends.
// Depends on nnis_pkg for the command and status types.
`default_nettype none

module nnis_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire nnis_pkg::cmd_t         din,
    input  wire logic                   pop,
    output nnis_pkg::cmd_t              dout,
    output nnis_pkg::fifo_status_t      status
);
    import nnis_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign dout         = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= din;
    end

endmodule

`default_nettype wire

@@ design/nnis_back.sv @@
// Back end of the scaler: holds the frame store, runs the restoring divider
// for both axes and drives the result register. Depends on nnis_pkg.
`default_nettype none

module nnis_back #(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_COLS   = 256,
    parameter int PIXEL_BITS = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire nnis_pkg::cfg_t cfg,
    input  wire logic           cmd_valid,
    input  wire nnis_pkg::cmd_t cmd,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [31:0]         m_tdata,   // pixel_out
    output logic                m_tuser    // out_of_range
);
    import nnis_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SIZE_W-1:0]  rrem_reg, rrem_next;
    logic [QUO_W-1:0]   rquo_reg, rquo_next;
    logic [SIZE_W-1:0]  crem_reg, crem_next;
    logic [QUO_W-1:0]   cquo_reg, cquo_next;
    logic               flag_reg, flag_next;
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_data_reg, out_data_next;
    logic               out_flag_reg, out_flag_next;
    logic [SIZE_W+QUO_W-1:0] rstep;
    logic [SIZE_W+QUO_W-1:0] cstep;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic [PIXEL_BITS-1:0] frame_store [DEPTH];
    logic [PIXEL_BITS-1:0] rdata_reg;

    // One restoring division step: shift in the next dividend bit and
    // subtract the divisor when it fits.
    function automatic logic [SIZE_W+QUO_W-1:0] div_step(
        input logic [SIZE_W-1:0] rem,
        input logic [QUO_W-1:0]  quo,
        input logic [SIZE_W-1:0] dst
    );
        logic [SIZE_W:0]   trial;
        logic              fits;
        logic [SIZE_W-1:0] rem_out;
        trial   = {rem, quo[QUO_W-1]};
        fits    = (trial >= {1'b0, dst});
        rem_out = fits ? SIZE_W'(trial - {1'b0, dst}) : trial[SIZE_W-1:0];
        return {rem_out, quo[QUO_W-2:0], fits};
    endfunction

    // Row-major store address.
    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [QUO_W-1:0] r,
        input logic [QUO_W-1:0] c
    );
        return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    endfunction

    assign rstep = div_step(rrem_reg, rquo_reg, cfg.dst_rows);
    assign cstep = div_step(crem_reg, cquo_reg, cfg.dst_cols);

    // Store address: the command's indices on a load, the quotients on a read.
    assign mem_addr = (state_reg == ST_IDLE)
                      ? store_addr({1'b0, cmd.row_idx}, {1'b0, cmd.col_idx})
                      : store_addr(rquo_reg, cquo_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rrem_next      = rrem_reg;
        rquo_next      = rquo_reg;
        crem_next      = crem_reg;
        cquo_next      = cquo_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_flag_next  = out_flag_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop = 1'b1;
                    case (cmd.op)
                        OP_LOAD:
                            mem_we = 1'b1;
                        OP_FETCH:
                        begin
                            rrem_next  = {1'b0, cmd.row_prod[PROD_W-1:QUO_W]};
                            rquo_next  = cmd.row_prod[QUO_W-1:0];
                            crem_next  = {1'b0, cmd.col_prod[PROD_W-1:QUO_W]};
                            cquo_next  = cmd.col_prod[QUO_W-1:0];
                            cnt_next   = '0;
                            state_next = ST_DIV;
                        end
                        default:
                        begin
                            flag_next  = 1'b1;
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                {rrem_next, rquo_next} = rstep;
                {crem_next, cquo_next} = cstep;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                flag_next  = 1'b0;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = flag_reg ? '0 : WORD_W'(rdata_reg);
                    out_flag_next  = flag_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State, divider and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rrem_reg      <= '0;
            rquo_reg      <= '0;
            crem_reg      <= '0;
            cquo_reg      <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rrem_reg      <= rrem_next;
            rquo_reg      <= rquo_next;
            crem_reg      <= crem_next;
            cquo_reg      <= cquo_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_flag_reg  <= out_flag_next;
        end
    end

    // Frame store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_store[mem_addr] <= PIXEL_BITS'(cmd.pixel);
        if (mem_re)
            rdata_reg <= frame_store[mem_addr];
    end

endmodule

`default_nettype wire

@@ design/nearest_neighbor_image_scaler.sv @@
// Nearest-neighbor image scaler top level: configuration registers and the
// front, queue and back ends. Depends on nnis_pkg, nnis_front, nnis_fifo, nnis_back.
//
// Usage:
//   The slave stream takes words of kind load (tuser 0) or fetch (tuser 1).
//   A load stores pixel_in at (row_index, col_index) of the source frame; it
//   gives a result only when the position lies outside the source size, and
//   then the result carries pixel 0 with out_of_range set.
//   A fetch names an output coordinate; each axis maps to
//   floor(index * src_size / dst_size) and the stored pixel is returned on the
//   master stream, or pixel 0 with out_of_range set when out of range.
//   Sizes are to be set over the APB port only while the block is idle, which
//   the block does not enforce; a size above the store dimension saturates to it.
// Sequencing:
//   A load in range is stored as it leaves the queue; a flagged word leaves
//   the queue and then loads the result. A fetch leaves the queue, runs nine
//   divider steps (both axes at once) and one store read, then loads the
//   result; the back end takes no new command until that result is loaded.
//   The two-entry queue keeps accepting words while the back end is busy.
// Reset and stall:
//   Reset clears the queue, the sequencer and the result register and sets
//   all sizes to 256; the frame store is not cleared. A receiver stall holds
//   the result; the back end waits at its next result and the queue then fills and drops tready.
`default_nettype none

module nearest_neighbor_image_scaler #(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_COLS   = 256,
    parameter int PIXEL_BITS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [47:0]                     s_tdata,  // row_index, col_index, pixel_in
    input  wire logic                            s_tuser,  // kind
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [31:0]                          m_tdata,  // pixel_out
    output logic                                 m_tuser,  // out_of_range
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [nnis_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [nnis_pkg::REG_W-1:0]      pwdata,
    output logic [nnis_pkg::REG_W-1:0]           prdata,
    output logic                                 pready
);
    import nnis_pkg::*;

    logic [SIZE_W-1:0] src_rows_reg;
    logic [SIZE_W-1:0] src_cols_reg;
    logic [SIZE_W-1:0] dst_rows_reg;
    logic [SIZE_W-1:0] dst_cols_reg;
    logic              cfg_write;
    logic [1:0]        reg_sel;
    cfg_t              cfg;
    logic              push;
    cmd_t              front_cmd;
    cmd_t              queue_cmd;
    fifo_status_t      fifo_status;
    logic              pop;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_rows_reg <= SIZE_W'(256);
            src_cols_reg <= SIZE_W'(256);
            dst_rows_reg <= SIZE_W'(256);
            dst_cols_reg <= SIZE_W'(256);
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_SRC_ROWS: src_rows_reg <= pwdata[SIZE_W-1:0];
                REG_SRC_COLS: src_cols_reg <= pwdata[SIZE_W-1:0];
                REG_DST_ROWS: dst_rows_reg <= pwdata[SIZE_W-1:0];
                REG_DST_COLS: dst_cols_reg <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_sel)
            REG_SRC_ROWS: prdata = REG_W'(src_rows_reg);
            REG_SRC_COLS: prdata = REG_W'(src_cols_reg);
            REG_DST_ROWS: prdata = REG_W'(dst_rows_reg);
            REG_DST_COLS: prdata = REG_W'(dst_cols_reg);
            default:      prdata = '0;
        endcase
    end

    // Saturate the sizes to the store dimensions.
    always_comb
    begin
        cfg.src_rows = (int'(src_rows_reg) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : src_rows_reg;
        cfg.src_cols = (int'(src_cols_reg) > MAX_COLS) ? SIZE_W'(MAX_COLS) : src_cols_reg;
        cfg.dst_rows = (int'(dst_rows_reg) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : dst_rows_reg;
        cfg.dst_cols = (int'(dst_cols_reg) > MAX_COLS) ? SIZE_W'(MAX_COLS) : dst_cols_reg;
    end

    nnis_front u_front (
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .fifo_status (fifo_status),
        .push        (push),
        .cmd         (front_cmd)
    );

    nnis_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (front_cmd),
        .pop    (pop),
        .dout   (queue_cmd),
        .status (fifo_status)
    );

    nnis_back #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (!fifo_status.empty),
        .cmd       (queue_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // A flagged result never carries pixel data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("out_of_range result with nonzero pixel");

    // An accepted word is waiting in the queue on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !fifo_status.empty)
        else $error("accepted word missing from the queue");

    // A write to the source height register takes the written value.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && reg_sel == REG_SRC_ROWS |=> src_rows_reg == $past(pwdata[SIZE_W-1:0]))
        else $error("source height register not updated");
`endif

endmodule

`default_nettype wire

@@ tb/nearest_neighbor_image_scaler_tb.sv @@
// Self-checking testbench for the nearest-neighbor image scaler.
// Drives load and fetch words, predicts each result, and sets sizes over APB.
// Depends on nnis_pkg and the nearest_neighbor_image_scaler top level.
`timescale 1ns / 100ps

module nearest_neighbor_image_scaler_tb;

    import nnis_pkg::*;

    localparam int FRAME_DIM     = 256;
    localparam int RANDOM_WORDS  = 1100;
    localparam int SETTLE_CYCLES = 30;
    localparam int QUIET_LIMIT   = 4000;

    // One word on the input stream.
    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [31:0]      pixel;
    } scaler_word_t;

    // One result word: the scaled pixel and its out-of-range flag.
    typedef struct packed {
        logic [31:0] pixel;
        logic        flag;
    } scaled_pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata = '0;  // row_index, col_index, pixel_in
    logic                  s_tuser = 1'b0; // kind
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;        // pixel_out
    logic                  m_tuser;        // out_of_range
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [REG_W-1:0]      pwdata = '0;
    logic [REG_W-1:0]      prdata;
    logic                  pready;

    // Words waiting to be sent and scaled pixels waiting to come back.
    scaler_word_t  scaler_words[$];
    scaled_pixel_t scaled_pixels[$];

    // Size registers as last written, raw 9-bit values.
    logic [SIZE_W-1:0] size_regs[4];

    // Source frame as the block should hold it, and which entries the
    // stimulus has loaded so far.
    logic [31:0] frame_copy[FRAME_DIM*FRAME_DIM];
    bit          pixel_loaded[FRAME_DIM*FRAME_DIM];

    scaler_word_t  cur_word;
    scaled_pixel_t want;
    bit            send_idling;
    bit            recv_idling;
    int            send_hold;
    int            recv_hold;
    int            quiet_cycles;
    int            error_count;
    int            words_queued;
    int            loads_sent;
    int            fetches_sent;
    int            results_seen;
    int            flags_seen;
    int            size_settings;

    nearest_neighbor_image_scaler u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // A size above the store dimension behaves as the dimension itself.
    function automatic int eff_size(input int idx);
        return (size_regs[idx] > FRAME_DIM) ? FRAME_DIM : int'(size_regs[idx]);
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_pixel();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 32'h0000_0000;
        else if (r == 1)
            return 32'hFFFF_FFFF;
        else
            return $urandom;
    endfunction

    // Work out the result of one accepted word and update the frame copy.
    function automatic void scale_and_fetch(input scaler_word_t w);
        int sr, sc, dr, dc, mr, mc;
        scaled_pixel_t res;
        sr = eff_size(REG_SRC_ROWS);
        sc = eff_size(REG_SRC_COLS);
        dr = eff_size(REG_DST_ROWS);
        dc = eff_size(REG_DST_COLS);
        res = '{pixel: 32'h0, flag: 1'b1};
        if (w.kind == KIND_LOAD) begin
            if (int'(w.row) >= sr || int'(w.col) >= sc)
                scaled_pixels.push_back(res);
            else
                frame_copy[{w.row, w.col}] = w.pixel;
        end
        else begin
            if (int'(w.row) < dr && int'(w.col) < dc && sr != 0 && sc != 0) begin
                mr = (int'(w.row) * sr) / dr;
                mc = (int'(w.col) * sc) / dc;
                res.pixel = frame_copy[mr * FRAME_DIM + mc];
                res.flag = 1'b0;
            end
            scaled_pixels.push_back(res);
        end
    endfunction

    // Queue one word; an in-range load marks its entry as loaded.
    task automatic queue_word(input logic kind, input int row, input int col,
                              input logic [31:0] pixel);
        scaler_word_t w;
        w.kind = kind;
        w.row = row[IDX_W-1:0];
        w.col = col[IDX_W-1:0];
        w.pixel = pixel;
        if (kind == KIND_LOAD && row < eff_size(REG_SRC_ROWS) && col < eff_size(REG_SRC_COLS))
            pixel_loaded[row * FRAME_DIM + col] = 1'b1;
        scaler_words.push_back(w);
        words_queued++;
    endtask

    // Queue a fetch; a mapped entry that was never loaded is loaded first.
    task automatic queue_fetch(input int row, input int col);
        int sr, sc, dr, dc, mr, mc;
        sr = eff_size(REG_SRC_ROWS);
        sc = eff_size(REG_SRC_COLS);
        dr = eff_size(REG_DST_ROWS);
        dc = eff_size(REG_DST_COLS);
        if (row < dr && col < dc && sr != 0 && sc != 0) begin
            mr = (row * sr) / dr;
            mc = (col * sc) / dc;
            if (!pixel_loaded[mr * FRAME_DIM + mc])
                queue_word(KIND_LOAD, mr, mc, rand_pixel());
        end
        queue_word(KIND_FETCH, row, col, $urandom);
    endtask

    // Random load, mostly inside the source frame.
    task automatic queue_load_random();
        int sr, sc, row, col;
        sr = eff_size(REG_SRC_ROWS);
        sc = eff_size(REG_SRC_COLS);
        row = (sr == 0) ? $urandom_range(0, 255) : $urandom_range(0, sr - 1);
        col = (sc == 0) ? $urandom_range(0, 255) : $urandom_range(0, sc - 1);
        if ($urandom_range(0, 9) == 0) begin
            if (sr < FRAME_DIM && $urandom_range(0, 1))
                row = $urandom_range(sr, 255);
            else if (sc < FRAME_DIM)
                col = $urandom_range(sc, 255);
        end
        queue_word(KIND_LOAD, row, col, rand_pixel());
    endtask

    // Random fetch, mostly inside the output frame.
    task automatic queue_fetch_random();
        int dr, dc, row, col;
        dr = eff_size(REG_DST_ROWS);
        dc = eff_size(REG_DST_COLS);
        row = (dr == 0) ? $urandom_range(0, 255) : $urandom_range(0, dr - 1);
        col = (dc == 0) ? $urandom_range(0, 255) : $urandom_range(0, dc - 1);
        if ($urandom_range(0, 9) == 0) begin
            if (dr < FRAME_DIM && $urandom_range(0, 1))
                row = $urandom_range(dr, 255);
            else if (dc < FRAME_DIM)
                col = $urandom_range(dc, 255);
        end
        queue_fetch(row, col);
    endtask

    // Wait until every word is sent and every result is back, then let the
    // back end finish any load that gives no result.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (scaler_words.size() != 0 || s_tvalid || scaled_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_size(input logic [1:0] idx, input logic [SIZE_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(REG_W-SIZE_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_regs[idx] = value;
    endtask

    task automatic set_sizes(input int sr, input int sc, input int dr, input int dc);
        wait_idle();
        write_size(REG_SRC_ROWS, sr[SIZE_W-1:0]);
        write_size(REG_SRC_COLS, sc[SIZE_W-1:0]);
        write_size(REG_DST_ROWS, dr[SIZE_W-1:0]);
        write_size(REG_DST_COLS, dc[SIZE_W-1:0]);
        size_settings++;
    endtask

    // Size choice for random phases: mostly small frames, some
    // extremes, zero and above-maximum values now and then.
    function automatic int pick_size(input int small_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 0;
        else if (r < 8)
            return $urandom_range(257, 511);
        else if (r < 20)
            return $urandom_range(0, 1) ? 1 : 256;
        else if (r < 70)
            return $urandom_range(1, small_max);
        else
            return $urandom_range(1, 256);
    endfunction

    // Input stream driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            send_hold = 0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                scale_and_fetch(cur_word);
                if (cur_word.kind == KIND_LOAD)
                    loads_sent++;
                else
                    fetches_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_hold > 0) begin
                    send_hold--;
                    s_tvalid <= 1'b0;
                end
                else if (scaler_words.size() != 0) begin
                    cur_word = scaler_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_word.pixel, cur_word.col, cur_word.row};
                    s_tuser  <= cur_word.kind;
                    send_hold = send_idling ? gap_len() : 0;
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            recv_hold = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (scaled_pixels.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: pixel %h flag %b",
                             $time, m_tdata, m_tuser);
                end
                else begin
                    want = scaled_pixels.pop_front();
                    results_seen++;
                    if (want.flag)
                        flags_seen++;
                    if (m_tdata !== want.pixel) begin
                        error_count++;
                        $display("%0t: pixel mismatch: expected %h, got %h",
                                 $time, want.pixel, m_tdata);
                    end
                    if (m_tuser !== want.flag) begin
                        error_count++;
                        $display("%0t: out-of-range mismatch: expected %b, got %b",
                                 $time, want.flag, m_tuser);
                    end
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_tready <= 1'b0;
            end
            else if (recv_idling && $urandom_range(0, 3) == 0) begin
                recv_hold = gap_len();
                m_tready <= (recv_hold == 0);
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus sequence.
    initial
    begin
        int sr, sc, dr, dc, n, r, c, phase, random_start;
        for (int i = 0; i < 4; i++)
            size_regs[i] = 9'd256;
        send_idling = 1'b1;
        recv_idling = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Corners of a full-size frame, mapped one to one.
        queue_word(KIND_LOAD, 0, 0, 32'hFFFF_FFFF);
        queue_word(KIND_LOAD, 255, 255, 32'h0000_0000);
        queue_word(KIND_LOAD, 0, 255, 32'hA5A5_A5A5);
        queue_word(KIND_LOAD, 255, 0, 32'h5A5A_5A5A);
        queue_fetch(0, 0);
        queue_fetch(255, 255);
        queue_fetch(0, 255);
        queue_fetch(255, 0);

        // Loads and fetches outside the frame, and a shrinking fetch.
        set_sizes(200, 100, 256, 50);
        queue_word(KIND_LOAD, 200, 5, 32'h1111_1111);
        queue_word(KIND_LOAD, 5, 100, 32'h2222_2222);
        queue_fetch(10, 50);
        queue_fetch(255, 49);

        // Zero source size: every load and fetch is out of range.
        set_sizes(0, 0, 256, 256);
        queue_word(KIND_LOAD, 0, 0, 32'h3333_3333);
        queue_fetch(0, 0);

        // Zero output size: every fetch is out of range, loads still store.
        set_sizes(256, 256, 0, 0);
        queue_word(KIND_LOAD, 3, 3, 32'h4444_4444);
        queue_fetch(0, 0);

        // Sizes above the maximum saturate to the full frame.
        set_sizes(511, 257, 511, 300);
        queue_word(KIND_LOAD, 255, 255, 32'h1234_5678);
        queue_fetch(255, 255);

        // Enlarging a single source pixel to the whole output.
        set_sizes(1, 1, 256, 256);
        queue_fetch(255, 255);
        queue_fetch(128, 0);

        // Random phases, each with its own sizes and idling.
        random_start = words_queued;
        phase = 0;
        while (words_queued - random_start < RANDOM_WORDS) begin
            if (phase == 0) begin
                sr = 256; sc = 256; dr = 256; dc = 256;
            end
            else if (phase == 1) begin
                sr = 1; sc = 1; dr = 1; dc = 1;
            end
            else begin
                sr = pick_size(12);
                sc = pick_size(12);
                dr = pick_size(32);
                dc = pick_size(32);
            end
            set_sizes(sr, sc, dr, dc);
            send_idling = ($urandom_range(0, 3) != 0);
            recv_idling = ($urandom_range(0, 3) != 0);

            // A small frame is loaded whole before it is scaled.
            if (eff_size(REG_SRC_ROWS) * eff_size(REG_SRC_COLS) <= 64) begin
                for (r = 0; r < eff_size(REG_SRC_ROWS); r++)
                    for (c = 0; c < eff_size(REG_SRC_COLS); c++)
                        queue_word(KIND_LOAD, r, c, rand_pixel());
            end
            n = $urandom_range(60, 120);
            repeat (n) begin
                if ($urandom_range(0, 99) < 40)
                    queue_load_random();
                else
                    queue_fetch_random();
            end
            phase++;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d loads and %0d fetches over %0d size settings.",
                 loads_sent, fetches_sent, size_settings);
        $display("Checked %0d results, %0d of them out of range.", results_seen, flags_seen);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
design/nnis_pkg.sv
design/nnis_front.sv
design/nnis_fifo.sv
design/nnis_back.sv
design/nearest_neighbor_image_scaler.sv
tb/nearest_neighbor_image_scaler_tb.sv
